// ===== rtl/core/sbte_pkg.sv =====
`default_nettype none
package sbte_pkg;

    localparam int unsigned QDEPTH = 2;

    localparam logic [7:0] BLOCK_LENGTH_RESET = 8'd168;
    localparam logic       REG_BLOCK_LENGTH   = 1'b0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } t_in_beat;

    typedef struct packed {
        logic [6:0] symbol;
        logic       line_end;
        logic       run_last;
    } t_out_beat;

    // one classified byte: up to two 6-bit groups
    typedef struct packed {
        logic [11:0] bits;
        logic        two;
        logic        close;
    } t_job;

    // 0-9, A-D, F, E, G-Z, a-z, <, >
    function automatic logic [6:0] symbol_of(input logic [5:0] idx);
        logic [6:0] code;
        case (idx) inside
            [6'd0:6'd9]:   code = 7'(idx) + 7'd48;
            [6'd10:6'd13]: code = 7'(idx) + 7'd55;
            6'd14:         code = 7'd70;
            6'd15:         code = 7'd69;
            [6'd16:6'd35]: code = 7'(idx) + 7'd55;
            [6'd36:6'd61]: code = 7'(idx) + 7'd61;
            6'd62:         code = 7'd60;
            default:       code = 7'd62;
        endcase
        return code;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/six_bit_text_encoder.sv =====
// Six-bit text encoder: packs bytes LSB first into 6-bit groups, maps each
// group to an ASCII symbol and closes a line every block_length bytes or at
// end of file, zero-padding leftover bits into one final symbol.
// Input queue side: i_item is taken when push is high and full is low.
// Result queue side: o_result holds the oldest symbol while empty is low;
// it is taken when pop is high.
// A byte yields one or two result beats; run_last marks its last one.
// The first symbol of a byte goes through the job queue and then into the
// output register before it shows on o_result. The output register gives
// one symbol per cycle while pop is high and jobs wait in the queue.
// A two-entry job queue sits between classification and symbol output, so
// input keeps flowing while a result waits; when pop stays low the queue
// fills and full rises. Reset clears leftover bits, line byte count and
// both queues, and sets block_length to 168. The user writes block_length
// (APB, address 0) only while idle; the block itself does not enforce it.
`default_nettype none
module six_bit_text_encoder (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 push,
    output logic                full,
    input  sbte_pkg::t_in_beat  i_item,
    output logic                empty,
    input  wire                 pop,
    output sbte_pkg::t_out_beat o_result,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [2:0]          paddr,
    input  wire  [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [7:0]     r_block_length;
    logic           accept;
    logic           q_empty;
    logic           q_pop;
    sbte_pkg::t_job front_job;
    sbte_pkg::t_job head_job;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == sbte_pkg::REG_BLOCK_LENGTH) ?
                    {24'd0, r_block_length} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_length <= sbte_pkg::BLOCK_LENGTH_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == sbte_pkg::REG_BLOCK_LENGTH) begin
            r_block_length <= pwdata[7:0];
        end
    end

    assign accept = push && !full;

    sbte_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_beat         (i_item),
        .i_block_length (r_block_length),
        .o_job          (front_job)
    );

    sbte_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_wdata (front_job),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_rdata (head_job),
        .o_empty (q_empty)
    );

    sbte_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (head_job),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .o_result  (o_result),
        .o_empty   (empty),
        .i_pop     (pop)
    );

endmodule
`default_nettype wire

// ===== rtl/core/sbte_front.sv =====
`default_nettype none
module sbte_front (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_accept,
    input  sbte_pkg::t_in_beat i_beat,
    input  wire  [7:0]         i_block_length,
    output sbte_pkg::t_job     o_job
);

    logic [3:0]  r_pend_bits, n_pend_bits;
    logic [2:0]  r_pend_cnt, n_pend_cnt;
    logic [7:0]  r_line_bytes, n_line_bytes;
    logic [2:0]  have;
    logic [11:0] acc;
    logic [8:0]  taken;
    logic        close;

    always_comb begin
        have  = (r_pend_cnt > 3'd4) ? 3'd4 : r_pend_cnt;
        acc   = 12'(r_pend_bits) | (12'(i_beat.data_byte) << have);
        taken = 9'(r_line_bytes) + 9'd1;
        close = i_beat.end_of_file || (taken >= 9'(i_block_length));

        o_job.bits  = acc;
        o_job.two   = have[2] || close;
        o_job.close = close;

        if (close) begin
            n_pend_bits  = 4'd0;
            n_pend_cnt   = 3'd0;
            n_line_bytes = 8'd0;
        end else begin
            n_pend_bits  = have[2] ? 4'd0 : acc[9:6];
            n_pend_cnt   = have[2] ? 3'd0 : have + 3'd2;
            n_line_bytes = taken[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits  <= 4'd0;
            r_pend_cnt   <= 3'd0;
            r_line_bytes <= 8'd0;
        end else if (i_accept) begin
            r_pend_bits  <= n_pend_bits;
            r_pend_cnt   <= n_pend_cnt;
            r_line_bytes <= n_line_bytes;
        end
    end

    a_cnt_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_cnt[0] == 1'b0 && r_pend_cnt <= 3'd4)
        else $error("odd or oversized leftover count");

    a_no_stale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_cnt == 3'd0 |-> r_pend_bits == 4'd0)
        else $error("leftover bits without count");

endmodule
`default_nettype wire

// ===== rtl/core/sbte_fifo.sv =====
`default_nettype none
module sbte_fifo (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  sbte_pkg::t_job i_wdata,
    output logic           o_full,
    input  wire            i_pop,
    output sbte_pkg::t_job o_rdata,
    output logic           o_empty
);

    localparam int unsigned AW = $clog2(sbte_pkg::QDEPTH);

    sbte_pkg::t_job r_mem [sbte_pkg::QDEPTH];
    logic [AW-1:0]  r_wptr, r_rptr;
    logic [AW:0]    r_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == (AW+1)'(sbte_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == AW'(sbte_pkg::QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == AW'(sbte_pkg::QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            r_count <= r_count + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW+1)'(sbte_pkg::QDEPTH))
        else $error("job queue overflow");

endmodule
`default_nettype wire

// ===== rtl/core/sbte_back.sv =====
`default_nettype none
module sbte_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  sbte_pkg::t_job      i_job,
    input  wire                 i_q_empty,
    output logic                o_q_pop,
    output sbte_pkg::t_out_beat o_result,
    output logic                o_empty,
    input  wire                 i_pop
);

    logic                r_phase;
    logic                r_valid;
    sbte_pkg::t_out_beat r_out;
    logic                load;
    logic                last;
    logic [5:0]          grp;

    assign load    = (!r_valid || i_pop) && !i_q_empty;
    assign last    = r_phase || !i_job.two;
    assign grp     = r_phase ? i_job.bits[11:6] : i_job.bits[5:0];
    assign o_q_pop = load && last;
    assign o_result = r_out;
    assign o_empty  = !r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_phase <= !last;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.symbol   <= sbte_pkg::symbol_of(grp);
            r_out.line_end <= last && i_job.close;
            r_out.run_last <= last;
        end
    end

    a_phase_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> !i_q_empty)
        else $error("second group without a job");

    a_phase_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && !last |=> r_phase && r_valid && !r_out.run_last)
        else $error("first group of a pair marked last");

endmodule
`default_nettype wire
